// ===== src/oag_pkg.sv =====
// Shared types and constants for the operand address generator.
`default_nettype none

package oag_pkg;

   // Register file geometry.
   localparam int REG_WORDS = 128;
   localparam int REG_IDX_W = $clog2(REG_WORDS);

   // Request kinds carried in req_type.
   localparam logic REQ_ADDR  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Addressing modes carried in aa_mode.
   typedef enum logic [1:0] {
      MODE_DIRECT   = 2'd0,
      MODE_IMMED    = 2'd1,
      MODE_INDIRECT = 2'd2,
      MODE_INDEXED  = 2'd3
   } aa_mode_type;

   // One request item as held in the compute stage.
   typedef struct packed {
      logic        req_type;
      logic [1:0]  aa_mode;
      logic        word_op;
      logic [15:0] pc_now;
      logic [7:0]  byte_a;
      logic [7:0]  byte_b;
      logic [7:0]  byte_c;
      logic [6:0]  reg_slot;
      logic [15:0] reg_value;
   } addr_req_type;

   // One result item.
   typedef struct packed {
      logic [15:0] eff_addr;
      logic [15:0] next_pc;
      logic        misaligned;
   } addr_rsp_type;

   // Register file write port.
   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] idx;
      logic [15:0]          data;
   } rf_wr_type;

endpackage

`default_nettype wire

// ===== src/oag_req_if.sv =====
// Request channel of the operand address generator.
`default_nettype none

interface oag_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [1:0]  aa_mode;
   logic        word_op;
   logic [15:0] pc_now;
   logic [7:0]  byte_a;
   logic [7:0]  byte_b;
   logic [7:0]  byte_c;
   logic [6:0]  reg_slot;
   logic [15:0] reg_value;

   modport source (
      output valid, req_type, aa_mode, word_op, pc_now, byte_a, byte_b, byte_c,
             reg_slot, reg_value,
      input  ready
   );

   modport sink (
      input  valid, req_type, aa_mode, word_op, pc_now, byte_a, byte_b, byte_c,
             reg_slot, reg_value,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/oag_rsp_if.sv =====
// Result channel of the operand address generator.
`default_nettype none

interface oag_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] eff_addr;
   logic [15:0] next_pc;
   logic        misaligned;

   modport source (
      output valid, eff_addr, next_pc, misaligned,
      input  ready
   );

   modport sink (
      input  valid, eff_addr, next_pc, misaligned,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/oag_regfile.sv =====
// Register file: synchronous word memory, per-word valid bits and write forwarding.
`default_nettype none

module oag_regfile
   import oag_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [REG_IDX_W-1:0] rd_idx,
   input  wire rf_wr_type            wr,
   output logic [15:0]               rd_data
);

   logic [15:0]          reg_words_mem [REG_WORDS];
   logic [15:0]          mem_rd_ff;
   logic [REG_WORDS-1:0] vld_ff;
   logic [REG_WORDS-1:0] vld_in;
   logic                 rd_vld_ff;
   logic                 fwd_ff;
   logic                 fwd_in;
   logic [15:0]          fwd_data_ff;

   // Memory write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         reg_words_mem[wr.idx] <= wr.data;
      end
   end

   // Memory read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rd_ff <= reg_words_mem[rd_idx];
      end
   end

   // A word never written since reset reads as zero.
   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.idx] = 1'b1;
      end
   end

   // A write landing on the same edge as the read is forwarded.
   assign fwd_in = wr.en && (wr.idx == rd_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_idx];
            fwd_ff    <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff <= wr.data;
      end
   end

   // Pick forwarded data, then memory data, then the reset value.
   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (rd_vld_ff) begin
         rd_data = mem_rd_ff;
      end else begin
         rd_data = 16'h0000;
      end
   end

endmodule

`default_nettype wire

// ===== src/oag_calc.sv =====
// Address calculation: mode decode, address and pc sums, alignment and writeback.
`default_nettype none

module oag_calc
   import oag_pkg::*;
(
   input  wire addr_req_type  req,
   input  wire logic [15:0]   reg_data,
   output addr_rsp_type       rsp,
   output rf_wr_type          wb
);

   logic [15:0] step;
   logic [15:0] disp;
   logic [15:0] idx_sum;

   assign step    = req.word_op ? 16'd2 : 16'd1;
   assign disp    = req.byte_a[0] ? {req.byte_c, req.byte_b} : {8'h00, req.byte_b};
   assign idx_sum = reg_data + disp;

   // Result fields for each mode; a register write returns all zeros.
   always_comb begin
      rsp     = '0;
      wb.en   = 1'b0;
      wb.idx  = req.byte_a[7:1];
      wb.data = reg_data + step;
      if (req.req_type == REQ_WRITE) begin
         wb.en   = 1'b1;
         wb.idx  = req.reg_slot;
         wb.data = req.reg_value;
      end else begin
         unique case (aa_mode_type'(req.aa_mode))
            MODE_DIRECT: begin
               rsp.eff_addr   = {8'h00, req.byte_a};
               rsp.next_pc    = req.pc_now + 16'd1;
               rsp.misaligned = req.word_op & req.byte_a[0];
            end
            MODE_IMMED: begin
               rsp.eff_addr = req.pc_now;
               rsp.next_pc  = req.pc_now + step;
            end
            MODE_INDIRECT: begin
               rsp.eff_addr   = reg_data;
               rsp.next_pc    = req.pc_now + 16'd1;
               rsp.misaligned = req.word_op & reg_data[0];
               wb.en          = req.byte_a[0];
            end
            MODE_INDEXED: begin
               rsp.eff_addr   = idx_sum;
               rsp.next_pc    = req.pc_now + (req.byte_a[0] ? 16'd3 : 16'd2);
               rsp.misaligned = req.word_op & (disp[0] | idx_sum[0]);
            end
            default: begin
               rsp = '0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/operand_address_generator.sv =====
// Operand address generator: 128-word register file and addressing-mode pipeline.
//
// req_ch carries one item per instruction operand: either a register write
// (req_type set) or an address request with mode, word flag, pc and the three
// operand bytes that follow the opcode. rsp_ch returns one item per request:
// operand address, pc after the operand bytes, and a misalignment flag.
// A register write returns zeros in all three fields.
// An accepted item is registered in the compute stage as the register file
// is read; as it leaves that stage, the result is computed, the register
// write or the autoincremented pointer is written back, and the result is
// loaded into the output register, where it is valid on rsp_ch.
// One item is accepted every cycle while rsp_ch does not stall; the single
// write port of the register file is used at most once per item, and a
// write on the same edge as the next item's read is forwarded to it.
// Reset clears all register words to zero at once through per-word valid
// bits, so no clearing pass is needed and requests are taken right away.
// When rsp_ch stalls, the output register holds its item, the compute stage
// holds one more, and req_ch.ready drops until the output drains.
`default_nettype none

module operand_address_generator
   import oag_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   oag_req_if.sink   req_ch,
   oag_rsp_if.source rsp_ch
);

   logic         accept;
   logic         s1_adv;
   logic         s1_vld_ff;
   logic         s1_vld_in;
   addr_req_type s1_req_ff;
   addr_req_type req_in;
   logic         rsp_vld_ff;
   logic         rsp_vld_in;
   addr_rsp_type rsp_ff;
   addr_rsp_type calc_rsp;
   rf_wr_type    calc_wb;
   rf_wr_type    rf_wr;
   logic [15:0]  rf_rd_data;

   // Handshakes: the compute stage frees up when its item moves out.
   assign s1_adv       = s1_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_vld_ff || s1_adv;
   assign accept       = req_ch.valid && req_ch.ready;

   assign req_in.req_type  = req_ch.req_type;
   assign req_in.aa_mode   = req_ch.aa_mode;
   assign req_in.word_op   = req_ch.word_op;
   assign req_in.pc_now    = req_ch.pc_now;
   assign req_in.byte_a    = req_ch.byte_a;
   assign req_in.byte_b    = req_ch.byte_b;
   assign req_in.byte_c    = req_ch.byte_c;
   assign req_in.reg_slot  = req_ch.reg_slot;
   assign req_in.reg_value = req_ch.reg_value;

   // Register file; reads the pointer or base word as the item is accepted.
   oag_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_idx  (req_ch.byte_a[7:1]),
      .wr      (rf_wr),
      .rd_data (rf_rd_data)
   );

   oag_calc u_calc (
      .req      (s1_req_ff),
      .reg_data (rf_rd_data),
      .rsp      (calc_rsp),
      .wb       (calc_wb)
   );

   // Writeback happens only as the item leaves the compute stage.
   always_comb begin
      rf_wr    = calc_wb;
      rf_wr.en = calc_wb.en && s1_adv;
   end

   // Stage valid flags.
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (s1_adv) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_in;
      end
      if (s1_adv) begin
         rsp_ff <= calc_rsp;
      end
   end

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.eff_addr   = rsp_ff.eff_addr;
   assign rsp_ch.next_pc    = rsp_ff.next_pc;
   assign rsp_ch.misaligned = rsp_ff.misaligned;

`ifndef SYNTHESIS
   // A stalled compute stage must not be overwritten by a new item.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s1_adv) |-> !accept)
      else $error("item accepted while compute stage is stalled");

   // A register write produces an all-zero result.
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_req_ff.req_type == REQ_WRITE) |=>
      (rsp_ff.eff_addr == 16'h0000 && rsp_ff.next_pc == 16'h0000 && !rsp_ff.misaligned))
      else $error("register write returned a nonzero result");

   // Byte operands are never flagged as misaligned.
   a_byte_aligned: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && !s1_req_ff.word_op) |=> !rsp_ff.misaligned)
      else $error("byte operand flagged as misaligned");

   // The register file is written only when an item leaves the compute stage.
   a_wr_gated: assert property (@(posedge clock) disable iff (reset)
      rf_wr.en |-> (s1_vld_ff && s1_adv))
      else $error("register file written without a moving item");
`endif

endmodule

`default_nettype wire
